// File: design/hplq_pkg.sv
// Package for the HDR pixel threshold quantizer.
// Holds item codes, register indexes, float constants and the float compare.
// No dependencies.
`timescale 1ns / 1ps
package hplq_pkg;

   // Item function codes
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_PIXEL = 1'b1;

   // Register indexes
   localparam logic CSR_NEGATIVE_COLOR  = 1'b0;
   localparam logic CSR_NONFINITE_COLOR = 1'b1;

   localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0]  LEVEL_MAX    = 8'd255;
   localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;

   typedef logic [31:0] float_bits_type;

   // True when the value is NaN or infinite
   function automatic logic is_nonfinite(input float_bits_type b);
      return b[30:23] == EXP_ALL_ONES;
   endfunction

   function automatic logic is_nan(input float_bits_type b);
      return (b[30:23] == EXP_ALL_ONES) && (b[22:0] != 23'd0);
   endfunction

   // IEEE ordered less-than: false when either side is NaN, +0 equals -0
   function automatic logic float_lt(input float_bits_type a, input float_bits_type b);
      logic lt;
      lt = 1'b0;
      if (is_nan(a) || is_nan(b)) begin
         lt = 1'b0;
      end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
         lt = 1'b0;
      end else if (a[31] && !b[31]) begin
         lt = 1'b1;
      end else if (!a[31] && b[31]) begin
         lt = 1'b0;
      end else if (!a[31]) begin
         lt = a[30:0] < b[30:0];
      end else begin
         lt = a[30:0] > b[30:0];
      end
      return lt;
   endfunction

   // Below zero: negative sign, not NaN, not a zero
   function automatic logic is_negative(input float_bits_type b);
      return b[31] && !is_nan(b) && (b[30:0] != 31'd0);
   endfunction

endpackage

// File: design/hdr_pixel_lut_quantizer.sv
// Top level of the HDR pixel threshold quantizer: search pipeline and output register.
// Depends on hplq_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   req_* carries one item per handshake. req_func = write stores req_entry_value
//   into threshold slot req_entry_index (slots at or past LEVELS+1 are dropped)
//   and gives no result. req_func = pixel converts the three float samples and
//   gives one rsp_pixel_word: 0xFFRRGGBB, or an override color when a channel
//   is negative (wins) or NaN/infinite.
//   csr_* writes the two override colors; write them only while idle.
//   Each channel is binary searched in a pipeline of clog2(LEVELS+2) steps
//   (9 for 256 levels). Each step owns a copy of the table for each channel,
//   so an item enters every cycle unless the output stalls: throughput 1 item
//   per cycle while no result waits or rsp_ready is high.
//   Table writes travel down the pipeline with the items, so a pixel sees
//   exactly the writes accepted before it.
//   When rsp_ready is low with a result waiting, the whole pipeline holds and
//   req_ready drops; nothing is lost or repeated.
//   Reset clears all valid bits and both colors; the table is undefined
//   until written.
//
module hdr_pixel_lut_quantizer
   import hplq_pkg::*;
#(
   parameter int LEVELS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [8:0]  req_entry_index,
   input  logic [31:0] req_entry_value,
   input  logic [31:0] req_red_sample,
   input  logic [31:0] req_green_sample,
   input  logic [31:0] req_blue_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pixel_word,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data
);

   localparam int DEPTH = LEVELS + 1;
   localparam int STEPS = $clog2(LEVELS + 2);
   localparam int AW    = $clog2(DEPTH);
   localparam int BW    = $clog2(LEVELS + 3);
   localparam logic [BW-1:0] HI_INIT  = BW'(LEVELS + 2);
   localparam logic [AW-1:0] ADDR0    = AW'((LEVELS + 2) / 2 - 1);

   logic advance;

   // Stage registers
   logic                vld_ff [STEPS];
   logic                fn_ff  [STEPS];
   logic [8:0]          wi_ff  [STEPS];
   logic [31:0]         wv_ff  [STEPS];
   logic [31:0]         x_ff   [STEPS][3];
   logic [BW-1:0]       lo_ff  [STEPS][3];
   logic [BW-1:0]       hi_ff  [STEPS][3];
   logic [31:0]         rd_ff  [STEPS][3];
   logic                neg_ff [STEPS];
   logic                nf_ff  [STEPS];

   // Step results
   logic [BW-1:0]       lo_in  [STEPS][3];
   logic [BW-1:0]       hi_in  [STEPS][3];
   logic [AW-1:0]       addr_in [STEPS][3];

   logic [31:0] neg_color_ff, nf_color_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic [31:0] req_x [3];

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_word = rsp_word_ff;

   assign req_x[0] = req_red_sample;
   assign req_x[1] = req_green_sample;
   assign req_x[2] = req_blue_sample;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         neg_color_ff <= 32'd0;
         nf_color_ff  <= 32'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NEGATIVE_COLOR:  neg_color_ff <= csr_wr_data;
            CSR_NONFINITE_COLOR: nf_color_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // One search step per stage: narrow the bounds, form the next probe address
   always_comb begin
      logic [BW:0]   mid;
      logic [BW:0]   nmid;
      for (int s = 0; s < STEPS; s++) begin
         for (int c = 0; c < 3; c++) begin
            lo_in[s][c] = lo_ff[s][c];
            hi_in[s][c] = hi_ff[s][c];
            mid = ({1'b0, lo_ff[s][c]} + {1'b0, hi_ff[s][c]}) >> 1;
            if (hi_ff[s][c] - lo_ff[s][c] >= BW'(2)) begin
               if (float_lt(x_ff[s][c], rd_ff[s][c])) begin
                  hi_in[s][c] = BW'(mid);
               end else begin
                  lo_in[s][c] = BW'(mid);
               end
            end
            nmid = ({1'b0, lo_in[s][c]} + {1'b0, hi_in[s][c]}) >> 1;
            addr_in[s][c] = (nmid == '0) ? '0 : AW'(nmid - 1'b1);
         end
      end
   end

   // Advance the stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STEPS; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int s = 1; s < STEPS; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fn_ff[0]  <= req_func;
         wi_ff[0]  <= req_entry_index;
         wv_ff[0]  <= req_entry_value;
         neg_ff[0] <= is_negative(req_red_sample) || is_negative(req_green_sample)
                      || is_negative(req_blue_sample);
         nf_ff[0]  <= is_nonfinite(req_red_sample) || is_nonfinite(req_green_sample)
                      || is_nonfinite(req_blue_sample);
         for (int c = 0; c < 3; c++) begin
            x_ff[0][c]  <= req_x[c];
            lo_ff[0][c] <= '0;
            hi_ff[0][c] <= HI_INIT;
         end
         for (int s = 1; s < STEPS; s++) begin
            fn_ff[s]  <= fn_ff[s-1];
            wi_ff[s]  <= wi_ff[s-1];
            wv_ff[s]  <= wv_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
            nf_ff[s]  <= nf_ff[s-1];
            for (int c = 0; c < 3; c++) begin
               x_ff[s][c]  <= x_ff[s-1][c];
               lo_ff[s][c] <= lo_in[s-1][c];
               hi_ff[s][c] <= hi_in[s-1][c];
            end
         end
      end
   end

   // Table copies: one per step and channel, written as the write item enters
   for (genvar s = 0; s < STEPS; s++) begin : g_step
      logic          wr_en;
      logic [8:0]    wr_idx;
      logic [31:0]   wr_val;
      if (s == 0) begin : g_first
         assign wr_en  = req_valid && (req_func == FUNC_WRITE);
         assign wr_idx = req_entry_index;
         assign wr_val = req_entry_value;
      end else begin : g_rest
         assign wr_en  = vld_ff[s-1] && (fn_ff[s-1] == FUNC_WRITE);
         assign wr_idx = wi_ff[s-1];
         assign wr_val = wv_ff[s-1];
      end
      for (genvar c = 0; c < 3; c++) begin : g_chan
         logic [31:0]   mem_q [DEPTH];
         logic [AW-1:0] rd_addr;
         if (s == 0) begin : g_a0
            assign rd_addr = ADDR0;
         end else begin : g_an
            assign rd_addr = addr_in[s-1][c];
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               if (wr_en && (32'(wr_idx) < DEPTH)) begin
                  mem_q[AW'(wr_idx)] <= wr_val;
               end
               rd_ff[s][c] <= mem_q[rd_addr];
            end
         end
      end
   end

   // Clamp the found position to a level and pack the word
   function automatic logic [7:0] to_level(input logic [BW-1:0] lo);
      logic [7:0] lvl;
      if (lo == '0) begin
         lvl = 8'd0;
      end else if (32'(lo) - 32'd1 > 32'(LEVEL_MAX)) begin
         lvl = LEVEL_MAX;
      end else begin
         lvl = 8'(32'(lo) - 32'd1);
      end
      return lvl;
   endfunction

   always_comb begin
      rsp_word_in = {ALPHA_OPAQUE, to_level(lo_in[STEPS-1][0]),
                     to_level(lo_in[STEPS-1][1]), to_level(lo_in[STEPS-1][2])};
      if (nf_ff[STEPS-1]) begin
         rsp_word_in = nf_color_ff;
      end
      if (neg_ff[STEPS-1]) begin
         rsp_word_in = neg_color_ff;
      end
   end

   // Output register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vld_ff[STEPS-1] && (fn_ff[STEPS-1] == FUNC_PIXEL);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

// File: design/hplq_checker.sv
// Port-level checks for the HDR pixel threshold quantizer, bound to the top level.
// Depends on hdr_pixel_lut_quantizer.
`timescale 1ns / 1ps
module hplq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_pixel_word
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_word))
      else $error("stalled result changed");

   // Input stalls exactly when a result waits
   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow output stall");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown after reset");

endmodule

bind hdr_pixel_lut_quantizer hplq_checker u_hplq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_pixel_word (rsp_pixel_word)
);

// File: bench/hdr_pixel_lut_quantizer_checker.sv
// Checker for the HDR pixel threshold quantizer: predicts each pixel word and compares.
// Watches req_/rsp_/csr_ ports of the block; depends on hplq_pkg for item codes.
`timescale 1ns / 1ps
module hdr_pixel_lut_quantizer_checker
   import hplq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_func,
   input  logic [8:0]  req_entry_index,
   input  logic [31:0] req_entry_value,
   input  logic [31:0] req_red_sample,
   input  logic [31:0] req_green_sample,
   input  logic [31:0] req_blue_sample,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_pixel_word,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data,
   output int          fail_count,
   output int          words_pending
);

   localparam int NUM_LEVELS = 256;
   localparam int SLOTS      = NUM_LEVELS + 1;

   logic [31:0] thresholds [SLOTS];
   logic [31:0] neg_word;
   logic [31:0] nonfin_word;
   logic [31:0] expected_words [$];

   function automatic logic nan_bits(input logic [31:0] b);
      return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
   endfunction

   // Ordered less-than on float bit patterns
   function automatic logic below(input logic [31:0] a, input logic [31:0] b);
      if (nan_bits(a) || nan_bits(b)) return 1'b0;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return 1'b0;
      if (a[31] != b[31]) return a[31];
      if (!a[31]) return a[30:0] < b[30:0];
      return a[30:0] > b[30:0];
   endfunction

   // Binary search of one channel against the table
   function automatic logic [7:0] level_of(input logic [31:0] s);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = NUM_LEVELS + 2;
      mid = (lo + hi) / 2;
      while (mid != lo) begin
         if (mid - 1 < SLOTS && below(s, thresholds[mid-1])) hi = mid;
         else lo = mid;
         mid = (lo + hi) / 2;
      end
      if (lo == 0) return 8'd0;
      if (lo - 1 > 255) return 8'd255;
      return 8'(lo - 1);
   endfunction

   function automatic logic [31:0] pixel_of(input logic [31:0] r, input logic [31:0] g,
                                            input logic [31:0] b);
      logic [31:0] w;
      logic        nf;
      logic        ng;
      nf = (r[30:23] == 8'hFF) || (g[30:23] == 8'hFF) || (b[30:23] == 8'hFF);
      ng = below(r, 32'h0) || below(g, 32'h0) || below(b, 32'h0);
      w = {8'hFF, level_of(r), level_of(g), level_of(b)};
      if (nf) w = nonfin_word;
      if (ng) w = neg_word;
      return w;
   endfunction

   assign words_pending = expected_words.size();

   always @(posedge clock) begin
      if (reset) begin
         neg_word <= '0;
         nonfin_word <= '0;
         fail_count <= 0;
         expected_words.delete();
      end else begin
         // Track register writes
         if (csr_wr_en) begin
            if (csr_index == CSR_NEGATIVE_COLOR) neg_word <= csr_wr_data;
            else nonfin_word <= csr_wr_data;
         end
         // Predict on accepted items
         if (req_valid && req_ready) begin
            if (req_func == FUNC_WRITE) begin
               if (req_entry_index < SLOTS) thresholds[req_entry_index] = req_entry_value;
            end else begin
               expected_words.push_back(pixel_of(req_red_sample, req_green_sample,
                                                 req_blue_sample));
            end
         end
         // Compare accepted results
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("pixel_word: expected none, actual %h", rsp_pixel_word);
               fail_count <= fail_count + 1;
            end else begin
               if (rsp_pixel_word !== expected_words[0]) begin
                  $error("pixel_word: expected %h, actual %h", expected_words[0],
                         rsp_pixel_word);
                  fail_count <= fail_count + 1;
               end
               void'(expected_words.pop_front());
            end
         end
      end
   end

endmodule

// File: bench/hdr_pixel_lut_quantizer_tb.sv
// Testbench top for the HDR pixel threshold quantizer: clock, reset, stimulus, verdict.
// Depends on hplq_pkg, hdr_pixel_lut_quantizer and hdr_pixel_lut_quantizer_checker.
`timescale 1ns / 1ps
module hdr_pixel_lut_quantizer_tb;
   import hplq_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_ITEMS = 95;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_func;
   logic [8:0]  req_entry_index;
   logic [31:0] req_entry_value;
   logic [31:0] req_red_sample;
   logic [31:0] req_green_sample;
   logic [31:0] req_blue_sample;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_pixel_word;
   logic        csr_wr_en;
   logic        csr_index;
   logic [31:0] csr_wr_data;
   int          fail_count;
   int          words_pending;
   int          cycle_count;
   logic        long_holdoff;

   hdr_pixel_lut_quantizer dut (.*);
   hdr_pixel_lut_quantizer_checker checker_i (.*);

   always begin
      clock = 1'b0; #1;
      clock = 1'b1; #1;
   end

   // Abort on runaway
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hdr_pixel_lut_quantizer regression: fail");
         $finish;
      end
   end

   // Receiver: random stalls, plus one long hold-off on request
   initial begin
      int gap;
      bit held;
      held = 1'b0;
      rsp_ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_holdoff && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Offer one item and hold it until accepted
   task automatic send_item(input logic f, input logic [8:0] idx, input logic [31:0] val,
                            input logic [31:0] r, input logic [31:0] g,
                            input logic [31:0] b, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_entry_index <= idx;
      req_entry_value <= val;
      req_red_sample <= r;
      req_green_sample <= g;
      req_blue_sample <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic pixel(input logic [31:0] r, input logic [31:0] g, input logic [31:0] b);
      send_item(FUNC_PIXEL, 9'($urandom), $urandom, r, g, b, 1'b0);
   endtask

   // Wait for every expected word, then let the pipeline empty
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Random float: mostly positive normal values, some specials
   function automatic logic [31:0] rand_sample(input int mode);
      case ($urandom_range(0, 9))
         0: return {$urandom_range(0, 1) == 1, 8'hFF,
                    23'($urandom_range(0, 1) ? $urandom : 0)};
         1: return {1'b1, 31'($urandom)};
         2: return {$urandom_range(0, 1) == 1, 31'd0};
         3: return $urandom;
         default: begin
            if (mode == 0) return {1'b0, 8'd127 + 8'($urandom_range(0, 8)), 23'($urandom)};
            return {1'b0, 8'd100 + 8'($urandom_range(0, 60)), 23'($urandom)};
         end
      endcase
   endfunction

   // Load an ascending table; mode 1 scatters a few NaN and unordered slots
   task automatic load_table(input int mode);
      logic [31:0] v;
      v = 32'h3B80_0000;
      for (int k = 0; k < 257; k++) begin
         if (mode == 1 && $urandom_range(0, 20) == 0)
            v = 32'h7FC0_0001 ^ 32'($urandom_range(0, 255));
         else if (mode == 1 && $urandom_range(0, 20) == 0) v = $urandom;
         else if (k == 0) v = 32'h0000_0000;
         else v = 32'h3B80_0000 + 32'(k) * 32'h0004_8000 + 32'($urandom_range(0, 7));
         send_item(FUNC_WRITE, 9'(k), v, $urandom, $urandom, $urandom,
                   1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      cycle_count = 0;
      long_holdoff = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_WRITE;
      req_entry_index = '0;
      req_entry_value = '0;
      req_red_sample = '0;
      req_green_sample = '0;
      req_blue_sample = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_NEGATIVE_COLOR;
      csr_wr_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, overrides and table corners
      load_table(0);
      pixel(32'h0000_0000, 32'h8000_0000, 32'h7F7F_FFFF);
      pixel(32'h7F80_0000, 32'h3F80_0000, 32'h3F00_0000);
      pixel(32'hFF80_0000, 32'h7FC0_0000, 32'h0000_0001);
      pixel(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h3B80_0000);
      pixel(32'h8000_0001, 32'h7F80_0000, 32'h4000_0000);
      pixel(32'h3B80_0000, 32'h3B84_8000, 32'h3C00_0000);
      drain();
      write_csr(CSR_NEGATIVE_COLOR, 32'hFFFF_FFFF);
      write_csr(CSR_NONFINITE_COLOR, 32'h1234_5678);
      send_item(FUNC_WRITE, 9'd257, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
      send_item(FUNC_WRITE, 9'd511, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0);
      send_item(FUNC_WRITE, 9'd256, 32'h7FC0_0000, 32'h0, 32'h0, 32'h0, 1'b0);
      pixel(32'h7F7F_FFFF, 32'h8000_0000, 32'h7F80_0001);
      pixel(32'hBF80_0000, 32'h7F80_0000, 32'h0);
      pixel(32'h4F00_0000, 32'h0000_0000, 32'h3F80_0000);
      drain();

      // Random phases with different colors
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_NEGATIVE_COLOR, 32'h0);
               write_csr(CSR_NONFINITE_COLOR, 32'hFFFF_FFFF);
            end
            1: begin
               write_csr(CSR_NEGATIVE_COLOR, $urandom);
               write_csr(CSR_NONFINITE_COLOR, 32'h0);
            end
            default: begin
               write_csr(CSR_NEGATIVE_COLOR, $urandom);
               write_csr(CSR_NONFINITE_COLOR, $urandom);
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 1 && n == 40) long_holdoff <= 1'b1;
            if ($urandom_range(0, 15) == 0)
               send_item(FUNC_WRITE, 9'($urandom_range(0, 300)),
                         32'h3B80_0000 + $urandom_range(0, 32'h0080_0000),
                         $urandom, $urandom, $urandom, 1'b0);
            else
               send_item(FUNC_PIXEL, 9'($urandom), $urandom, rand_sample(phase & 1),
                         rand_sample(phase & 1), rand_sample(phase & 1),
                         (phase == 1 && n < 80) || $urandom_range(0, 3) == 0);
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("hdr_pixel_lut_quantizer regression: pass");
      end else begin
         $display("hdr_pixel_lut_quantizer regression: fail");
      end
      $finish;
   end

endmodule
